@@ src/key_value_store_min_max_assert.svh @@
// Assertion macros for the key/value store checker.
// Needs clk and rst in the scope of each use.
`ifndef KEY_VALUE_STORE_MIN_MAX_ASSERT_SVH
`define KEY_VALUE_STORE_MIN_MAX_ASSERT_SVH

// Same-cycle implication.
`define KVS_ASSERT_NOW(name, cond, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("kvs check failed");

// Next-cycle implication.
`define KVS_ASSERT_NEXT(name, cond, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("kvs check failed");

`endif

@@ src/kvs_pkg.sv @@
// Shared constants, codes and types of the key/value store.
// No dependencies.
package kvs_pkg;

  localparam int CAPACITY   = 256;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int FUNC_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  localparam int IN_BITS     = FUNC_W + KEY_BITS + VALUE_BITS;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = STATUS_W + KEY_BITS + VALUE_BITS + CNT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef logic [FUNC_W-1:0]   func_t;
  typedef logic [STATUS_W-1:0] kvs_status_t;

  localparam func_t FUNC_INSERT = 3'd0;
  localparam func_t FUNC_DELETE = 3'd1;
  localparam func_t FUNC_SEARCH = 3'd2;
  localparam func_t FUNC_MIN    = 3'd3;
  localparam func_t FUNC_MAX    = 3'd4;

  localparam kvs_status_t STATUS_OK        = 2'd0;
  localparam kvs_status_t STATUS_NOT_FOUND = 2'd1;
  localparam kvs_status_t STATUS_FULL      = 2'd2;

  typedef struct packed {
    logic             start;
    logic             step;
    logic             want_max;
    logic             entry_valid;
    logic [IDX_W-1:0] slot;
  } scan_ctl_t;

  typedef struct packed {
    logic                match_hit;
    logic [IDX_W-1:0]    match_slot;
    logic                free_hit;
    logic [IDX_W-1:0]    free_slot;
    logic                best_hit;
    logic [IDX_W-1:0]    best_slot;
    logic [KEY_BITS-1:0] best_key;
  } scan_res_t;

endpackage

@@ src/kvs_scan.sv @@
// Scan tracker: folds one stored entry per step into exact match,
// lowest free slot and min/max key. Depends on kvs_pkg.
module kvs_scan (
  input  logic                         clk,
  input  logic                         rst,
  input  kvs_pkg::scan_ctl_t           ctl,
  input  logic [kvs_pkg::KEY_BITS-1:0] search_key,
  input  logic [kvs_pkg::KEY_BITS-1:0] entry_key,
  output kvs_pkg::scan_res_t           res
);
  import kvs_pkg::*;

  logic better;

  always_comb begin
    if (ctl.want_max) begin
      better = entry_key > res.best_key;
    end else begin
      better = entry_key < res.best_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.match_hit <= 1'b0;
      res.free_hit  <= 1'b0;
      res.best_hit  <= 1'b0;
    end else if (ctl.start) begin
      res.match_hit <= 1'b0;
      res.free_hit  <= 1'b0;
      res.best_hit  <= 1'b0;
    end else if (ctl.step) begin
      if (ctl.entry_valid && !res.match_hit && entry_key == search_key) begin
        res.match_hit  <= 1'b1;
        res.match_slot <= ctl.slot;
      end
      if (!ctl.entry_valid && !res.free_hit) begin
        res.free_hit  <= 1'b1;
        res.free_slot <= ctl.slot;
      end
      if (ctl.entry_valid && (!res.best_hit || better)) begin
        res.best_hit  <= 1'b1;
        res.best_slot <= ctl.slot;
        res.best_key  <= entry_key;
      end
    end
  end

endmodule

@@ src/key_value_store_min_max.sv @@
// Key/value store with min/max lookup: top level. Depends on kvs_pkg, kvs_scan.
// Keys and values live in two single-port-read memories; valid bits in flops.
//
// One request is taken at a time. Every request except an unknown func sweeps
// the key memory, one entry per cycle, before the change is applied in S_APPLY;
// search, min or max that returns a pair then reads the value memory in S_FETCH.
// An unknown func goes from acceptance straight to S_DONE. The next request is
// taken only after the result is loaded, so it also waits while the previous
// result is held by back-pressure. Valid bits clear at reset, so no clearing
// pass is needed. The result sits in an output register; a new request is
// accepted while it waits.
module key_value_store_min_max (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [kvs_pkg::IN_TDATA_W-1:0]  s_tdata,  // func, key, value, zero pad
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [kvs_pkg::OUT_TDATA_W-1:0] m_tdata   // status, found_key,
                                                    // found_value, entry_count,
                                                    // zero pad
);
  import kvs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_APPLY = 5'b00100,
    S_FETCH = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;

  logic [KEY_BITS-1:0]   key_mem   [CAPACITY];
  logic [VALUE_BITS-1:0] value_mem [CAPACITY];
  logic [CAPACITY-1:0]   entry_valid;
  logic [CNT_W-1:0]      count;

  func_t                 cmd_func;
  logic [KEY_BITS-1:0]   cmd_key;
  logic [VALUE_BITS-1:0] cmd_value;

  logic [CNT_W-1:0]      issue_cnt;
  logic                  rd_pending;
  logic [IDX_W-1:0]      rd_slot;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic [IDX_W-1:0]      value_raddr;

  kvs_status_t           res_status;
  logic [KEY_BITS-1:0]   res_key;
  logic [VALUE_BITS-1:0] res_value;
  logic [OUT_TDATA_W-1:0] out_data;

  scan_ctl_t             scan_ctl;
  scan_res_t             scan_res;

  logic                  accept;
  logic                  issuing;
  logic                  known_func;
  logic                  out_free;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign issuing  = (state == S_SCAN) && (issue_cnt < CNT_W'(CAPACITY));
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = out_data;

  always_comb begin
    case (s_tdata[FUNC_W-1:0])
      FUNC_INSERT, FUNC_DELETE, FUNC_SEARCH, FUNC_MIN, FUNC_MAX: known_func = 1'b1;
      default: known_func = 1'b0;
    endcase
  end

  always_comb begin
    scan_ctl.start       = accept;
    scan_ctl.step        = rd_pending;
    scan_ctl.want_max    = (cmd_func == FUNC_MAX);
    scan_ctl.entry_valid = entry_valid[rd_slot];
    scan_ctl.slot        = rd_slot;
  end

  kvs_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .ctl        (scan_ctl),
    .search_key (cmd_key),
    .entry_key  (key_q),
    .res        (scan_res)
  );

  always_comb begin
    if (cmd_func == FUNC_SEARCH) begin
      value_raddr = scan_res.match_slot;
    end else begin
      value_raddr = scan_res.best_slot;
    end
  end

  // Key memory: sweep read, insert write.
  always_ff @(posedge clk) begin
    key_q <= key_mem[issue_cnt[IDX_W-1:0]];
    if (state == S_APPLY && cmd_func == FUNC_INSERT && !scan_res.match_hit &&
        scan_res.free_hit) begin
      key_mem[scan_res.free_slot] <= cmd_key;
    end
  end

  // Value memory: result read, insert write.
  always_ff @(posedge clk) begin
    value_q <= value_mem[value_raddr];
    if (state == S_APPLY && cmd_func == FUNC_INSERT) begin
      if (scan_res.match_hit) begin
        value_mem[scan_res.match_slot] <= cmd_value;
      end else if (scan_res.free_hit) begin
        value_mem[scan_res.free_slot] <= cmd_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_func  <= s_tdata[FUNC_W-1:0];
      cmd_key   <= s_tdata[FUNC_W +: KEY_BITS];
      cmd_value <= s_tdata[FUNC_W+KEY_BITS +: VALUE_BITS];
    end
    rd_slot <= issue_cnt[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_valid <= '0;
      count       <= '0;
      issue_cnt   <= '0;
      rd_pending  <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      rd_pending <= issuing;
      if (issuing) begin
        issue_cnt <= issue_cnt + CNT_W'(1);
      end
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            issue_cnt <= '0;
            res_key   <= '0;
            res_value <= '0;
            if (known_func) begin
              res_status <= STATUS_OK;
              state      <= S_SCAN;
            end else begin
              res_status <= STATUS_NOT_FOUND;
              state      <= S_DONE;
            end
          end
        end

        S_SCAN: begin
          if (!issuing && !rd_pending) begin
            state <= S_APPLY;
          end
        end

        S_APPLY: begin
          case (cmd_func)
            FUNC_INSERT: begin
              state <= S_DONE;
              if (!scan_res.match_hit) begin
                if (scan_res.free_hit) begin
                  entry_valid[scan_res.free_slot] <= 1'b1;
                  count <= count + CNT_W'(1);
                end else begin
                  res_status <= STATUS_FULL;
                end
              end
            end
            FUNC_DELETE: begin
              state <= S_DONE;
              if (scan_res.match_hit) begin
                entry_valid[scan_res.match_slot] <= 1'b0;
                count <= count - CNT_W'(1);
              end
            end
            FUNC_SEARCH: begin
              if (scan_res.match_hit) begin
                res_key <= cmd_key;
                state   <= S_FETCH;
              end else begin
                res_status <= STATUS_NOT_FOUND;
                state      <= S_DONE;
              end
            end
            FUNC_MIN, FUNC_MAX: begin
              if (scan_res.best_hit) begin
                res_key <= scan_res.best_key;
                state   <= S_FETCH;
              end else begin
                res_status <= STATUS_NOT_FOUND;
                state      <= S_DONE;
              end
            end
            default: begin
              res_status <= STATUS_NOT_FOUND;
              state      <= S_DONE;
            end
          endcase
        end

        S_FETCH: begin
          res_value <= value_q;
          state     <= S_DONE;
        end

        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_data <= {(OUT_TDATA_W - OUT_BITS)'(0), count, res_value, res_key, res_status};
    end
  end

endmodule

@@ src/kvs_checker.sv @@
// Port-level checker for the key/value store, bound to the top level.
// Depends on kvs_pkg and key_value_store_min_max_assert.svh.
`include "key_value_store_min_max_assert.svh"

module kvs_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [kvs_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import kvs_pkg::*;

  kvs_status_t      status;
  logic [CNT_W-1:0] entry_count;
  logic             pair_zero;

  assign status      = m_tdata[STATUS_W-1:0];
  assign entry_count = m_tdata[STATUS_W+KEY_BITS+VALUE_BITS +: CNT_W];
  assign pair_zero   = (m_tdata[STATUS_W +: KEY_BITS+VALUE_BITS] == '0);

  `KVS_ASSERT_NEXT(out_hold_a, m_tvalid && !m_tready, m_tvalid)
  `KVS_ASSERT_NEXT(one_at_a_time_a, s_tvalid && s_tready, !s_tready)
  `KVS_ASSERT_NOW(miss_no_pair_a, m_tvalid && status != STATUS_OK, pair_zero)
  `KVS_ASSERT_NOW(full_count_a, m_tvalid && status == STATUS_FULL, entry_count == CNT_W'(CAPACITY))
  `KVS_ASSERT_NOW(count_bound_a, m_tvalid, entry_count <= CNT_W'(CAPACITY))

endmodule

bind key_value_store_min_max kvs_checker u_kvs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ tb/kvs_store_checker.sv @@
// Scoreboard for the key/value store: watches both stream channels, predicts
// each result from its own copy of the stored pairs and compares field by field.
// Depends on kvs_pkg.
module kvs_store_checker
  import kvs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // func, key, value, zero pad
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,   // status, found_key, found_value,
                                            // entry_count, zero pad
  input  logic                   end_check,
  output int                     mismatch_count,
  output int                     results_seen,
  output int                     results_owed,
  output int                     full_seen
);

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] val_t;

  typedef struct packed {
    kvs_status_t      status;
    key_t             found_key;
    val_t             found_value;
    logic [CNT_W-1:0] entry_count;
  } kv_result_t;

  val_t       stored_pairs [key_t];
  kv_result_t owed_results [$];
  logic       end_done = 1'b0;

  function automatic kv_result_t apply_request(func_t f, key_t k, val_t v);
    kv_result_t r;
    key_t       idx;
    int         found;
    r        = '0;
    r.status = STATUS_OK;
    idx      = '0;
    found    = 0;
    case (f)
      FUNC_INSERT: begin
        if (stored_pairs.exists(k)) begin
          stored_pairs[k] = v;
        end else if (stored_pairs.num() >= CAPACITY) begin
          r.status = STATUS_FULL;
        end else begin
          stored_pairs[k] = v;
        end
      end
      FUNC_DELETE: begin
        if (stored_pairs.exists(k)) stored_pairs.delete(k);
      end
      FUNC_SEARCH: begin
        if (stored_pairs.exists(k)) begin
          r.found_key   = k;
          r.found_value = stored_pairs[k];
        end else begin
          r.status = STATUS_NOT_FOUND;
        end
      end
      FUNC_MIN, FUNC_MAX: begin
        if (f == FUNC_MIN) found = stored_pairs.first(idx);
        else               found = stored_pairs.last(idx);
        if (found == 1) begin
          r.found_key   = idx;
          r.found_value = stored_pairs[idx];
        end else begin
          r.status = STATUS_NOT_FOUND;
        end
      end
      default: r.status = STATUS_NOT_FOUND;
    endcase
    r.entry_count = CNT_W'(stored_pairs.num());
    return r;
  endfunction

  always @(posedge clk) begin
    kv_result_t want;
    kv_result_t got;
    if (rst) begin
      stored_pairs.delete();
      owed_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.status      = m_tdata[STATUS_W-1:0];
        got.found_key   = m_tdata[STATUS_W +: KEY_BITS];
        got.found_value = m_tdata[STATUS_W+KEY_BITS +: VALUE_BITS];
        got.entry_count = m_tdata[STATUS_W+KEY_BITS+VALUE_BITS +: CNT_W];
        results_seen++;
        if (got.status == STATUS_FULL) full_seen++;
        if (owed_results.size() == 0) begin
          $error("result with no request outstanding: status %0d", got.status);
          mismatch_count++;
        end else begin
          want = owed_results.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatch_count++;
          end
          if (got.found_key !== want.found_key) begin
            $error("found_key: expected %h, got %h", want.found_key, got.found_key);
            mismatch_count++;
          end
          if (got.found_value !== want.found_value) begin
            $error("found_value: expected %h, got %h", want.found_value, got.found_value);
            mismatch_count++;
          end
          if (got.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
            mismatch_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        owed_results.push_back(apply_request(s_tdata[FUNC_W-1:0],
                                             s_tdata[FUNC_W +: KEY_BITS],
                                             s_tdata[FUNC_W+KEY_BITS +: VALUE_BITS]));
      end
      if (end_check && !end_done) begin
        end_done = 1'b1;
        if (owed_results.size() != 0) begin
          $error("%0d results never arrived", owed_results.size());
          mismatch_count += owed_results.size();
        end
      end
    end
    results_owed = owed_results.size();
  end

endmodule

@@ tb/tb_key_value_store_min_max.sv @@
// Testbench top for key_value_store_min_max: clock, reset, request stimulus with
// bursts and gaps, result back-pressure and the verdict.
// Depends on kvs_pkg, the block and kvs_store_checker.
module tb_key_value_store_min_max;
  import kvs_pkg::*;

  localparam int          POOL_N     = 48;
  localparam int          DRAIN_WAIT = 300;
  localparam int unsigned CYCLE_CAP  = 4_000_000;

  localparam func_t FUNC_BAD_FIRST = 3'd5;
  localparam func_t FUNC_BAD_LAST  = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  logic        req_taken = 1'b0;
  logic        end_check = 1'b0;
  int unsigned cycle_count = 0;
  int          mismatch_count;
  int          results_seen;
  int          results_owed;
  int          full_seen;

  logic [KEY_BITS-1:0] key_pool [POOL_N];
  logic [KEY_BITS-1:0] fill_keys [$];
  int                  burst_left = 0;
  int                  stall_left = 0;
  int                  op_count [8];

  key_value_store_min_max u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  kvs_store_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .end_check      (end_check),
    .mismatch_count (mismatch_count),
    .results_seen   (results_seen),
    .results_owed   (results_owed),
    .full_seen      (full_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    req_taken   <= s_tvalid && s_tready;
  end

  // Stall the result side at random, with ready-only stretches.
  always @(negedge clk) begin
    if (cycle_count[12]) begin
      m_tready <= 1'b1;
    end else begin
      if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 12);
      else if (stall_left > 0) stall_left = stall_left - 1;
      m_tready <= (stall_left == 0);
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_CAP);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, results_owed);
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_request(func_t f, logic [KEY_BITS-1:0] k, logic [VALUE_BITS-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 280) : $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W-IN_BITS){1'b0}}, v, k, f};
    do @(negedge clk); while (!req_taken);
    burst_left--;
    op_count[f]++;
  endtask

  function automatic logic [KEY_BITS-1:0] pick_key();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return key_pool[$urandom_range(0, POOL_N-1)];
    if (sel < 85 && fill_keys.size() > 0) return fill_keys[$urandom_range(0, fill_keys.size()-1)];
    return $urandom;
  endfunction

  task automatic random_request(int insert_pct, int delete_pct);
    int    sel;
    func_t f;
    sel = $urandom_range(0, 99);
    if (sel < insert_pct) begin
      f = FUNC_INSERT;
    end else if (sel < insert_pct + delete_pct) begin
      f = FUNC_DELETE;
    end else begin
      sel = $urandom_range(0, 9);
      if (sel < 5)      f = FUNC_SEARCH;
      else if (sel < 7) f = FUNC_MIN;
      else if (sel < 9) f = FUNC_MAX;
      else              f = func_t'($urandom_range(FUNC_BAD_FIRST, FUNC_BAD_LAST));
    end
    send_request(f, pick_key(), $urandom);
  endtask

  initial begin
    logic [KEY_BITS-1:0] fill_key;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < POOL_N; i++) key_pool[i] = $urandom;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty store, missing keys and unused codes
    send_request(FUNC_MIN,    32'h1234_5678, 32'h0);
    send_request(FUNC_MAX,    32'h0,         32'h0);
    send_request(FUNC_SEARCH, 32'h0,         32'h0);
    send_request(FUNC_DELETE, 32'h5,         32'h0);
    send_request(3'd5,        32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(3'd6,        32'h0,         32'h0);
    send_request(3'd7,        32'hAAAA_5555, 32'h5555_AAAA);
    // extreme keys and values, overwrite, lookups
    send_request(FUNC_INSERT, 32'h0,         32'hFFFF_FFFF);
    send_request(FUNC_INSERT, 32'hFFFF_FFFF, 32'h0);
    send_request(FUNC_INSERT, 32'h8000_0000, 32'hA5A5_A5A5);
    send_request(FUNC_MIN,    32'hFFFF_FFFF, 32'h0);
    send_request(FUNC_MAX,    32'h0,         32'h0);
    send_request(FUNC_SEARCH, 32'h8000_0000, 32'h0);
    send_request(FUNC_INSERT, 32'h0,         32'h1234_5678);
    send_request(FUNC_SEARCH, 32'h0,         32'h0);
    send_request(FUNC_SEARCH, 32'h1,         32'h0);
    send_request(FUNC_DELETE, 32'hFFFF_FFFF, 32'h0);
    send_request(FUNC_MAX,    32'h0,         32'h0);
    send_request(FUNC_DELETE, 32'hFFFF_FFFF, 32'h0);
    send_request(FUNC_DELETE, 32'h0,         32'h0);
    send_request(FUNC_DELETE, 32'h8000_0000, 32'h0);
    send_request(FUNC_MIN,    32'h0,         32'h0);
    send_request(FUNC_SEARCH, 32'h8000_0000, 32'h0);

    repeat (700) random_request(35, 20);

    // fill past capacity with distinct keys
    fill_key = $urandom;
    repeat (300) begin
      fill_key = fill_key + 32'h9E37_79B1;
      fill_keys.push_back(fill_key);
      send_request(FUNC_INSERT, fill_key, $urandom);
    end

    repeat (727) random_request(25, 40);

    s_tvalid <= 1'b0;
    wait (results_owed == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);
    end_check <= 1'b1;
    repeat (2) @(posedge clk);

    $display("sent insert %0d, delete %0d, search %0d, min %0d, max %0d, unused codes %0d",
             op_count[FUNC_INSERT], op_count[FUNC_DELETE], op_count[FUNC_SEARCH],
             op_count[FUNC_MIN], op_count[FUNC_MAX],
             op_count[5] + op_count[6] + op_count[7]);
    $display("checked %0d results, %0d rejected on a full store, %0d mismatches",
             results_seen, full_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ key_value_store_min_max.f @@
+incdir+src
src/kvs_pkg.sv
src/kvs_scan.sv
src/key_value_store_min_max.sv
src/kvs_checker.sv
tb/kvs_store_checker.sv
tb/tb_key_value_store_min_max.sv
